[src/mvm_pkg.sv]
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector multiplier
// Item layouts, function codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

   // default store dimension
   localparam int MAX_DIM_DEF = 8;

   // data format: signed Q16.16
   localparam int VALUE_W = 32;
   localparam int Q_FRAC  = 16;

   // function codes of an input item
   localparam logic [1:0] FUNC_MATRIX  = 2'd0;
   localparam logic [1:0] FUNC_VECTOR  = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE = 2'd2;

   // configuration register indexes
   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   // reset value of both count registers
   localparam logic [3:0] COUNT_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]                func;
      logic [2:0]                row;
      logic [2:0]                col;
      logic signed [VALUE_W-1:0] value;
      logic [3:0]                vector_length;
   } req_type;

   typedef struct packed {
      logic [2:0]                index;
      logic signed [VALUE_W-1:0] result;
      logic                      dim_error;
      logic                      last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

[src/mvm_store.sv]
// ----------------------------------------------------------------------------
// mvm_store: matrix and vector element memories
// One write port per memory; both read at the same column in the same cycle,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_store #(
   parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF,
   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_mat,
   input  logic                              wr_vec,
   input  logic [IDX_W-1:0]                  wr_row,
   input  logic [IDX_W-1:0]                  wr_col,
   input  logic signed [mvm_pkg::VALUE_W-1:0] wr_value,
   input  logic                              rd_en,
   input  logic [IDX_W-1:0]                  rd_row,
   input  logic [IDX_W-1:0]                  rd_col,
   output logic                              rd_valid,
   output logic signed [mvm_pkg::VALUE_W-1:0] rd_mat,
   output logic signed [mvm_pkg::VALUE_W-1:0] rd_vec
);
   import mvm_pkg::*;

   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int MA_W      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

   logic [VALUE_W-1:0] mat_mem [MAT_DEPTH];
   logic [VALUE_W-1:0] vec_mem [MAX_DIM];

   logic [MA_W-1:0]    wr_addr;
   logic [MA_W-1:0]    rd_addr;
   logic [VALUE_W-1:0] rd_mat_ff;
   logic [VALUE_W-1:0] rd_vec_ff;
   logic               rd_valid_ff;
   logic               rd_valid_in;

   // row-major element address
   assign wr_addr = MA_W'(wr_row) * MA_W'(MAX_DIM) + MA_W'(wr_col);
   assign rd_addr = MA_W'(rd_row) * MA_W'(MAX_DIM) + MA_W'(rd_col);

   // write ports
   always_ff @(posedge clock) begin
      if (wr_mat) begin
         mat_mem[wr_addr] <= wr_value;
      end
      if (wr_vec) begin
         vec_mem[wr_col] <= wr_value;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mat_ff <= mat_mem[rd_addr];
         rd_vec_ff <= vec_mem[rd_col];
      end
   end

   assign rd_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_mat   = rd_mat_ff;
   assign rd_vec   = rd_vec_ff;

endmodule

`default_nettype wire

[src/mvm_mac.sv]
// ----------------------------------------------------------------------------
// mvm_mac: shared multiply-accumulate unit
// Registered 32x32 product, exact wide accumulator, floor to Q16.16 and
// saturate to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_mac #(
   parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [mvm_pkg::VALUE_W-1:0] mat_value,
   input  logic signed [mvm_pkg::VALUE_W-1:0] vec_value,
   input  logic                              clear,
   output logic                              busy,
   output logic signed [mvm_pkg::VALUE_W-1:0] sum_sat
);
   import mvm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int PROD_W = 2 * VALUE_W;
   localparam int ACC_W  = PROD_W + CNT_W;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_floor;

   // product stage
   assign prod_in = mat_value * vec_value;

   always_ff @(posedge clock) begin
      if (in_valid) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate stage, clear between rows
   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         prod_valid_ff <= in_valid;
         acc_ff        <= acc_in;
      end
   end

   // floor to Q16.16, then saturate
   assign acc_floor = acc_ff >>> Q_FRAC;

   always_comb begin
      if (acc_floor > SAT_HI) begin
         sum_sat = 32'sh7FFF_FFFF;
      end else if (acc_floor < SAT_LO) begin
         sum_sat = 32'sh8000_0000;
      end else begin
         sum_sat = acc_floor[VALUE_W-1:0];
      end
   end

   assign busy = prod_valid_ff;

endmodule

`default_nettype wire

[src/matrix_vector_multiply.sv]
// ----------------------------------------------------------------------------
// matrix_vector_multiply: Q16.16 matrix-vector multiplier
// Element loads into matrix and vector memories, row-by-row dot products
// on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Load items (func 0, func 1) write one element each. A compute item (func 2)
// walks the active rows one at a time; each row streams its columns through
// the memory read port and the single multiply-accumulate unit, one column
// per cycle, and drains the unit before the row result is loaded.
// req_stall stays high for the whole compute. The row result sits in an
// output register, so the next row is already being computed while it waits.
// The memories are undefined until written; no clearing pass runs after reset.
`default_nettype none

module matrix_vector_multiply #(
   parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mvm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mvm_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [3:0]       csr_wdata
);
   import mvm_pkg::*;

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W = $clog2(MAX_DIM + 1);

   state_type          state_ff, state_in;
   logic [3:0]         row_count_ff, row_count_in;
   logic [3:0]         col_count_ff, col_count_in;
   logic [CNT_W-1:0]   rows_ff, rows_in;
   logic [CNT_W-1:0]   cols_ff, cols_in;
   logic               err_ff, err_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               row_ok;
   logic               col_ok;
   logic               wr_mat;
   logic               wr_vec;
   logic               start;
   logic [CNT_W-1:0]   rows_lim;
   logic [CNT_W-1:0]   cols_lim;
   logic               row_last;
   logic               col_last;
   logic               out_free;
   logic               rd_en;
   logic               rd_valid;
   logic signed [VALUE_W-1:0] rd_mat;
   logic signed [VALUE_W-1:0] rd_vec;
   logic               acc_clear;
   logic               mac_busy;
   logic signed [VALUE_W-1:0] sum_sat;
   logic               load_rsp;

   // input handshake: take items only while idle
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // decode load items, drop writes outside the stores
   assign row_ok = (32'(req_data.row) < MAX_DIM);
   assign col_ok = (32'(req_data.col) < MAX_DIM);
   assign wr_mat = req_accept && (req_data.func == FUNC_MATRIX) && row_ok && col_ok;
   assign wr_vec = req_accept && (req_data.func == FUNC_VECTOR) && col_ok;
   assign start  = req_accept && (req_data.func == FUNC_COMPUTE);

   // clamp counts to the store size
   assign rows_lim = (32'(row_count_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(row_count_ff);
   assign cols_lim = (32'(col_count_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(col_count_ff);

   assign row_last = (CNT_W'(row_ff) + CNT_W'(1)) == rows_ff;
   assign col_last = (CNT_W'(col_ff) + CNT_W'(1)) == cols_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   mvm_store #(
      .MAX_DIM (MAX_DIM)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_mat   (wr_mat),
      .wr_vec   (wr_vec),
      .wr_row   (IDX_W'(req_data.row)),
      .wr_col   (IDX_W'(req_data.col)),
      .wr_value (req_data.value),
      .rd_en    (rd_en),
      .rd_row   (row_ff),
      .rd_col   (col_ff),
      .rd_valid (rd_valid),
      .rd_mat   (rd_mat),
      .rd_vec   (rd_vec)
   );

   mvm_mac #(
      .MAX_DIM (MAX_DIM)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid),
      .mat_value (rd_mat),
      .vec_value (rd_vec),
      .clear     (acc_clear),
      .busy      (mac_busy),
      .sum_sat   (sum_sat)
   );

   // configuration writes
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: fetch columns of a row, drain the MAC, emit the row result
   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      err_in    = err_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      rd_en     = 1'b0;
      acc_clear = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rows_in = rows_lim;
               cols_in = cols_lim;
               err_in  = (col_count_ff != req_data.vector_length);
               row_in  = '0;
               col_in  = '0;
               if (rows_lim != '0) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (cols_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               rd_en = 1'b1;
               if (col_last) begin
                  col_in   = '0;
                  state_in = ST_DRAIN;
               end else begin
                  col_in = col_ff + IDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!rd_valid && !mac_busy && out_free) begin
               load_rsp  = 1'b1;
               acc_clear = 1'b1;
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: load a row result, drop it once taken
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         rsp_data_in.index     = 3'(row_ff);
         rsp_data_in.result    = err_ff ? '0 : sum_sat;
         rsp_data_in.dim_error = err_ff;
         rsp_data_in.last      = row_last;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= COUNT_RESET;
         col_count_ff <= COUNT_RESET;
         rows_ff      <= '0;
         cols_ff      <= '0;
         err_ff       <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         err_ff       <= err_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[src/mvm_checker.sv]
// ----------------------------------------------------------------------------
// mvm_checker: port-level checks for the matrix-vector multiplier
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mvm_pkg::rsp_type rsp_data
);
   import mvm_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // a dimension mismatch always yields a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dim_error |-> rsp_data.result == '0)
      else $error("dim_error with nonzero result");

   // rows remain while a non-final result waits, so no new item is taken
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("input taken in the middle of a compute");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (.*);

`default_nettype wire
